FILE: rtl/npm_pkg.sv
// Package for the polynomial multiplier core: field constants, Barrett factor,
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package npm_pkg;

	localparam int CoeffW     = 30;
	localparam int DegW       = 6;
	localparam int StoreDepth = 64;
	localparam int AddrW      = $clog2(StoreDepth);
	localparam int CntW       = DegW + 2;
	localparam int SumW       = DegW + 1;
	localparam int DefCapacity = 64;

	localparam logic [CoeffW-1:0] Modulus = CoeffW'(998244353);
	// Barrett factor floor(2^60 / p), fits 31 bits
	localparam logic [63:0] MuWide = (64'd1 << 60) / 64'd998244353;
	localparam logic [30:0] Mu = MuWide[30:0];

	localparam logic [1:0] CfgFirstDeg  = 2'd0;
	localparam logic [1:0] CfgSecondDeg = 2'd1;

	typedef struct packed {
		logic first;   // first term of a coefficient sum
		logic lastterm;// last term of a coefficient sum
		logic final_c; // coefficient is the last of the product
	} tag_t;

	typedef struct packed {
		logic             we;
		logic             wsel;   // 0: first store, 1: second store
		logic [AddrW-1:0] waddr;
		logic             issue;
		logic [AddrW-1:0] ra;
		logic [AddrW-1:0] rb;
		tag_t             tag;
		logic             err;
	} cmd_t;

	typedef struct packed {
		logic idle;
	} status_t;

endpackage

FILE: rtl/npm_mulmod.sv
// Pipelined modular multiplier over GF(998244353), Barrett reduction, four stages.
// Depends on npm_pkg.
`timescale 1ns / 1ps

module npm_mulmod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [npm_pkg::CoeffW-1:0] a,
	input  logic [npm_pkg::CoeffW-1:0] b,
	input  npm_pkg::tag_t             in_tag,
	output logic                      out_valid,
	output logic [npm_pkg::CoeffW-1:0] r,
	output npm_pkg::tag_t             out_tag,
	output logic                      busy
);
	import npm_pkg::*;

	logic [3:0]  v_q;
	tag_t        tag_s1, tag_s2, tag_s3, tag_s4;
	logic [59:0] prod_s1;
	logic [61:0] t_s2;
	logic [31:0] x_s2, x_s3, qp_s3;
	logic [CoeffW-1:0] r_s4;
	logic [31:0] d0, d1, d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[2:0], in_valid};
		end
	end

	// full product
	always_ff @(posedge clk) begin
		prod_s1 <= 60'(a) * 60'(b);
		tag_s1  <= in_tag;
	end

	// quotient estimate
	always_ff @(posedge clk) begin
		t_s2   <= 62'(prod_s1[59:29]) * 62'(Mu);
		x_s2   <= prod_s1[31:0];
		tag_s2 <= tag_s1;
	end

	always_ff @(posedge clk) begin
		qp_s3  <= 32'(t_s2[61:31]) * 32'(Modulus);
		x_s3   <= x_s2;
		tag_s3 <= tag_s2;
	end

	// remainder is below three times the modulus
	always_comb begin
		d0 = x_s3 - qp_s3;
		d1 = (d0 >= {2'b0, Modulus}) ? d0 - {2'b0, Modulus} : d0;
		d2 = (d1 >= {2'b0, Modulus}) ? d1 - {2'b0, Modulus} : d1;
	end

	always_ff @(posedge clk) begin
		r_s4   <= d2[CoeffW-1:0];
		tag_s4 <= tag_s3;
	end

	assign out_valid = v_q[3];
	assign r         = r_s4;
	assign out_tag   = tag_s4;
	assign busy      = |v_q;

endmodule

FILE: rtl/npm_datapath.sv
// Datapath: coefficient stores, multiply pipeline, accumulator and output register.
// Depends on npm_pkg and npm_mulmod.
`timescale 1ns / 1ps

module npm_datapath (
	input  logic                      clk,
	input  logic                      arst_n,
	input  npm_pkg::cmd_t             cmd,
	output npm_pkg::status_t          status,
	input  logic [npm_pkg::CoeffW-1:0] coeff,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [31:0]               m_tdata,
	output logic                      m_tlast,
	output logic                      m_tuser
);
	import npm_pkg::*;

	logic [CoeffW-1:0] first_store [StoreDepth];
	logic [CoeffW-1:0] second_store [StoreDepth];
	logic [CoeffW-1:0] wdata;
	logic [CoeffW-1:0] ra_s1, rb_s1;
	tag_t              tag_s1;
	logic              v_s1;
	logic              mv;
	logic [CoeffW-1:0] mr;
	tag_t              mtag;
	logic              mbusy;
	logic [CoeffW-1:0] acc_q, out_q;
	logic [CoeffW:0]   sum;
	logic [CoeffW-1:0] red;
	logic              last_q, err_q, valid_q;

	// reduce once on load
	assign wdata = (coeff >= Modulus) ? coeff - Modulus : coeff;

	always_ff @(posedge clk) begin
		if (cmd.we && !cmd.wsel) first_store[cmd.waddr] <= wdata;
		if (cmd.we && cmd.wsel) second_store[cmd.waddr] <= wdata;
		ra_s1  <= first_store[cmd.ra];
		rb_s1  <= second_store[cmd.rb];
		tag_s1 <= cmd.tag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
		end
	end

	npm_mulmod u_mul (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s1), .a(ra_s1), .b(rb_s1), .in_tag(tag_s1),
		.out_valid(mv), .r(mr), .out_tag(mtag), .busy(mbusy)
	);

	always_comb begin
		sum = {1'b0, (mtag.first ? {CoeffW{1'b0}} : acc_q)} + {1'b0, mr};
		red = (sum >= {1'b0, Modulus}) ? CoeffW'(sum - {1'b0, Modulus}) : sum[CoeffW-1:0];
	end

	always_ff @(posedge clk) begin
		if (mv) acc_q <= red;
		if (cmd.err) begin
			out_q  <= '0;
			last_q <= 1'b1;
			err_q  <= 1'b1;
		end else if (mv && mtag.lastterm) begin
			out_q  <= red;
			last_q <= mtag.final_c;
			err_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.err || (mv && mtag.lastterm)) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid    = valid_q;
	assign m_tdata     = {2'b0, out_q};
	assign m_tlast     = last_q;
	assign m_tuser     = err_q;
	assign status.idle = !v_s1 && !mbusy && !valid_q;

endmodule

FILE: rtl/npm_ctrl.sv
// Controller: degree registers, load counter and the convolution sequencer.
// Depends on npm_pkg.
`timescale 1ns / 1ps

module npm_ctrl #(
	parameter int TRANSFORM_CAPACITY = npm_pkg::DefCapacity
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [npm_pkg::DegW-1:0]   cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	output npm_pkg::cmd_t              cmd,
	input  npm_pkg::status_t           status
);
	import npm_pkg::*;

	typedef enum logic [2:0] {
		S_LOAD, S_CHECK, S_SETUP, S_ISSUE, S_DRAIN, S_ERR
	} state_t;

	state_t            state_q;
	logic [DegW-1:0]   d1_q, d2_q;
	logic [CntW-1:0]   cnt_q;
	logic [SumW-1:0]   sum_q;
	logic [AddrW-1:0]  k_q, i_q, hi_q;
	logic              first_q;
	logic              issue_q, err_q;
	logic [AddrW-1:0]  ra_q, rb_q;
	tag_t              tag_q;
	logic [CntW-1:0]   n1, total, cnt_b;
	logic              load_beat, cfg_hit;
	logic [CntW-1:0]   len;

	// smallest power of two above the summed degree
	function automatic logic [CntW-1:0] next_len(input logic [SumW-1:0] s);
		logic [CntW-1:0] l;
		l = CntW'(1);
		for (int n = 0; n < SumW; n++) begin
			if (l <= CntW'(s)) l = l << 1;
		end
		return l;
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_LOAD);
	assign load_beat = s_tvalid && s_tready;
	assign cfg_hit   = cfg_valid && (cfg_index inside {CfgFirstDeg, CfgSecondDeg});
	assign n1        = CntW'(d1_q) + CntW'(1);
	assign total     = n1 + CntW'(d2_q) + CntW'(1);
	assign cnt_b     = cnt_q - n1;
	assign len       = next_len(sum_q);

	assign cmd.we    = load_beat;
	assign cmd.wsel  = (cnt_q >= n1);
	assign cmd.waddr = (cnt_q >= n1) ? cnt_b[AddrW-1:0] : cnt_q[AddrW-1:0];
	assign cmd.issue = issue_q;
	assign cmd.ra    = ra_q;
	assign cmd.rb    = rb_q;
	assign cmd.tag   = tag_q;
	assign cmd.err   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			d1_q    <= '0;
			d2_q    <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			k_q     <= '0;
			i_q     <= '0;
			hi_q    <= '0;
			first_q <= 1'b0;
			issue_q <= 1'b0;
			err_q   <= 1'b0;
			ra_q    <= '0;
			rb_q    <= '0;
			tag_q   <= '0;
		end else begin
			issue_q <= 1'b0;
			err_q   <= 1'b0;
			if (cfg_hit) begin
				if (cfg_index == CfgFirstDeg) d1_q <= cfg_data;
				else d2_q <= cfg_data;
				cnt_q   <= '0;
				state_q <= S_LOAD;
			end else begin
				case (state_q)
					S_LOAD: begin
						if (load_beat) begin
							cnt_q <= cnt_q + CntW'(1);
							if (cnt_q + CntW'(1) == total) begin
								sum_q   <= SumW'(d1_q) + SumW'(d2_q);
								state_q <= S_CHECK;
							end
						end
					end
					S_CHECK: begin
						k_q <= '0;
						if (len > CntW'(TRANSFORM_CAPACITY)) begin
							err_q   <= 1'b1;
							state_q <= S_ERR;
						end else begin
							state_q <= S_SETUP;
						end
					end
					S_SETUP: begin
						i_q     <= (k_q > d2_q) ? k_q - d2_q : '0;
						hi_q    <= (k_q < d1_q) ? k_q : d1_q;
						first_q <= 1'b1;
						state_q <= S_ISSUE;
					end
					S_ISSUE: begin
						issue_q       <= 1'b1;
						ra_q          <= i_q;
						rb_q          <= k_q - i_q;
						tag_q.first   <= first_q;
						tag_q.lastterm <= (i_q == hi_q);
						tag_q.final_c <= (SumW'(k_q) == sum_q);
						first_q       <= 1'b0;
						i_q           <= i_q + AddrW'(1);
						if (i_q == hi_q) state_q <= S_DRAIN;
					end
					S_DRAIN: begin
						// wait until the coefficient has left the output register
						if (!issue_q && status.idle) begin
							if (SumW'(k_q) == sum_q) begin
								cnt_q   <= '0;
								state_q <= S_LOAD;
							end else begin
								k_q     <= k_q + AddrW'(1);
								state_q <= S_SETUP;
							end
						end
					end
					S_ERR: begin
						if (!err_q && status.idle) begin
							cnt_q   <= '0;
							state_q <= S_LOAD;
						end
					end
					default: state_q <= S_LOAD;
				endcase
			end
		end
	end

endmodule

FILE: rtl/ntt_polynomial_multiplier_core.sv
// Top level of the polynomial multiplier over GF(998244353).
// Depends on npm_pkg, npm_ctrl, npm_datapath.
//
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+--------------------------------------
// s_       | in  | s_tvalid / s_tready  | tdata[29:0] coeff
// m_       | out | m_tvalid / m_tready  | tdata[29:0] product_coeff, tlast, tuser error
// cfg_     | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data degree
//
// Loading takes one beat a cycle. Once the last coefficient is in, each product
// coefficient k issues its terms one after another through the store read, the
// four-stage modular multiplier and the output register; the sequencer starts the
// next coefficient only when that one has left the output register, and the single
// multiplier carries all terms. Reset clears the control state only; stores are
// always written before they are read, so no clearing pass runs. A stall on
// the output side holds the sequencer until the beat is taken.
`timescale 1ns / 1ps

module ntt_polynomial_multiplier_core #(
	parameter int TRANSFORM_CAPACITY = npm_pkg::DefCapacity
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [31:0]              s_tdata,   // [29:0] coeff, [31:30] zero
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [31:0]              m_tdata,   // [29:0] product_coeff, [31:30] zero
	output logic                     m_tlast,
	output logic                     m_tuser,   // [0] error
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [npm_pkg::DegW-1:0] cfg_data
);
	import npm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: degrees, load count, term and coefficient loops
	npm_ctrl #(.TRANSFORM_CAPACITY(TRANSFORM_CAPACITY)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready),
		.cmd(cmd), .status(status)
	);

	// stores, multiply-accumulate and the output register
	npm_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .status(status),
		.coeff(s_tdata[CoeffW-1:0]),
		.m_tvalid(m_tvalid), .m_tready(m_tready),
		.m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
	);

endmodule

FILE: rtl/npm_checker.sv
// Port-level checks for the polynomial multiplier core, bound to the top level.
// Depends on ntt_polynomial_multiplier_core.
`timescale 1ns / 1ps

module npm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("error beat not marked last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("error beat carries data");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input accepted while a result is pending");

endmodule

bind ntt_polynomial_multiplier_core npm_checker u_npm_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
	.m_tlast(m_tlast), .m_tuser(m_tuser)
);
